FILE: hw/rtl/frame_pacing_regulator_assert.svh
// Assertion macros shared by the RTL; each expects clk and rst_n in scope.
`ifndef FRAME_PACING_REGULATOR_ASSERT_SVH
`define FRAME_PACING_REGULATOR_ASSERT_SVH

// Check a condition at every edge outside reset.
`define FPR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define FPR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

    localparam int TIME_W    = 48;
    localparam int DUR_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam int WINDOW_ENTRIES_DEF = 4;

    localparam logic [DUR_W-1:0] TARGET_RESET  = 32'd33333;
    localparam logic [DUR_W-1:0] OVERRUN_RESET = 32'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET  = 2'd0,
        CFG_OVERRUN = 2'd1
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: hw/rtl/frame_pacing_regulator.sv
// Frame pacing regulator: takes one time poll per cycle when the output side is
// not stalled and returns one result per poll. A poll is registered, then judged
// combinationally against the running sum of the last WINDOW_ENTRIES-1 completed
// frame durations; this loop (48-bit subtract, running-sum add, threshold compare)
// fixes the rate at one poll per clock. The reported average goes through a
// three-stage divide by the entry count (reciprocal multiply in two halves, then
// one correction). Configuration writes take effect at once and should be made
// while idle.
`default_nettype none
`include "frame_pacing_regulator_assert.svh"

module frame_pacing_regulator #(
    parameter int WINDOW_ENTRIES = fpr_pkg::WINDOW_ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_wr_en,
    input  wire logic [fpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fpr_pkg::DUR_W-1:0]      cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [fpr_pkg::TIME_W-1:0]     time_now,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                frame_started,
    output logic [fpr_pkg::DUR_W-1:0]           smoothed_delta
);

    localparam int TIME_W = fpr_pkg::TIME_W;
    localparam int DUR_W  = fpr_pkg::DUR_W;
    localparam int HIST_D = WINDOW_ENTRIES - 1;
    localparam int CNT_W  = $clog2(WINDOW_ENTRIES);
    localparam int DIV_W  = $clog2(WINDOW_ENTRIES + 1);
    localparam int SUM_W  = DUR_W + CNT_W;
    localparam int THR_W  = DUR_W + DIV_W;
    localparam int LO_W   = SUM_W / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int REC_SH = SUM_W;
    localparam int REC_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + REC_W;

    // reciprocal of each entry count, scaled by 2^REC_SH, rounded down
    logic [REC_W-1:0] recip_tab [WINDOW_ENTRIES];

    for (genvar k = 0; k < WINDOW_ENTRIES; k++) begin : g_recip
        localparam logic [REC_W-1:0] RECIP = REC_W'((64'd1 << REC_SH) / (k + 1));
        assign recip_tab[k] = RECIP;
    end

    // configuration
    logic [DUR_W-1:0] target_reg;
    logic [DUR_W-1:0] overrun_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= fpr_pkg::TARGET_RESET;
            overrun_reg <= fpr_pkg::OVERRUN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fpr_pkg::CFG_TARGET:  target_reg  <= cfg_data;
                fpr_pkg::CFG_OVERRUN: overrun_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage load enables, back from the output
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    assign ld5      = !v5_reg || out_ready;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    // stage 1: poll register
    logic [TIME_W-1:0] time1_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
            time1_reg <= time_now;
    end

    // pacing state
    logic [TIME_W-1:0] start_time_reg, start_time_next;
    logic [SUM_W-1:0]  hist_sum_reg, hist_sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DUR_W-1:0]  hist_reg [HIST_D];

    logic [TIME_W-1:0] diff;
    logic [DUR_W-1:0]  pending;
    logic [SUM_W-1:0]  sum_now;
    logic [DIV_W-1:0]  div_now;
    logic [THR_W-1:0]  thr_avg;
    logic [DUR_W:0]    thr_pend;
    logic              hist_full;
    logic              start_now;
    logic              fire1;

    assign diff      = time1_reg - start_time_reg;
    assign pending   = (|diff[TIME_W-1:DUR_W]) ? '1 : diff[DUR_W-1:0];
    assign sum_now   = hist_sum_reg + SUM_W'(pending);
    assign div_now   = DIV_W'(count_reg) + DIV_W'(1);
    assign thr_avg   = THR_W'(target_reg) * THR_W'(div_now);
    assign thr_pend  = {1'b0, target_reg} + {1'b0, overrun_reg};
    assign hist_full = (count_reg == CNT_W'(HIST_D));
    // average below target is the same as sum below target times count
    assign start_now = !((THR_W'(sum_now) < thr_avg) &&
                         ({1'b0, pending} < thr_pend));
    assign fire1     = v1_reg && ld2;

    always_comb
    begin
        start_time_next = start_time_reg;
        hist_sum_next   = hist_sum_reg;
        count_next      = count_reg;
        if (fire1 && start_now)
        begin
            start_time_next = time1_reg;
            // drop the oldest duration once the history is full
            hist_sum_next   = sum_now - (hist_full ? SUM_W'(hist_reg[HIST_D-1]) : '0);
            if (!hist_full)
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            hist_sum_reg   <= '0;
            count_reg      <= '0;
        end
        else
        begin
            start_time_reg <= start_time_next;
            hist_sum_reg   <= hist_sum_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire1 && start_now)
        begin
            hist_reg[0] <= pending;
            for (int i = 1; i < HIST_D; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    // stage 2: decision
    logic             start2_reg;
    logic [SUM_W-1:0] sum2_reg;
    logic [CNT_W-1:0] cnt2_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            start2_reg <= start_now;
            sum2_reg   <= sum_now;
            cnt2_reg   <= count_reg;
        end
    end

    // stage 3: reciprocal partial products
    logic                   start3_reg;
    logic [SUM_W-1:0]       sum3_reg;
    logic [CNT_W-1:0]       cnt3_reg;
    logic [LO_W+REC_W-1:0]  pp_lo3_reg;
    logic [HI_W+REC_W-1:0]  pp_hi3_reg;
    logic [REC_W-1:0]       recip2;

    assign recip2 = recip_tab[cnt2_reg];

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            start3_reg <= start2_reg;
            sum3_reg   <= sum2_reg;
            cnt3_reg   <= cnt2_reg;
            pp_lo3_reg <= (LO_W+REC_W)'(sum2_reg[LO_W-1:0]) * (LO_W+REC_W)'(recip2);
            pp_hi3_reg <= (HI_W+REC_W)'(sum2_reg[SUM_W-1:LO_W]) * (HI_W+REC_W)'(recip2);
        end
    end

    // stage 4: combine halves into the estimate
    logic              start4_reg;
    logic [SUM_W-1:0]  sum4_reg;
    logic [CNT_W-1:0]  cnt4_reg;
    logic [DUR_W-1:0]  q4_reg;
    logic [PROD_W-1:0] prod3;

    assign prod3 = (PROD_W'(pp_hi3_reg) << LO_W) + PROD_W'(pp_lo3_reg);

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            start4_reg <= start3_reg;
            sum4_reg   <= sum3_reg;
            cnt4_reg   <= cnt3_reg;
            q4_reg     <= prod3[REC_SH+DUR_W-1:REC_SH];
        end
    end

    // stage 5: the estimate is low by at most one; correct it
    logic [DIV_W-1:0] d4;
    logic [SUM_W-1:0] qd4;
    logic [SUM_W-1:0] rem;
    logic [DUR_W-1:0] quo;
    logic             started5_reg;
    logic [DUR_W-1:0] delta5_reg;

    assign d4  = DIV_W'(cnt4_reg) + DIV_W'(1);
    assign qd4 = SUM_W'(q4_reg) * SUM_W'(d4);
    assign rem = sum4_reg - qd4;
    assign quo = (rem >= SUM_W'(d4)) ? q4_reg + DUR_W'(1) : q4_reg;

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            started5_reg <= start4_reg;
            delta5_reg   <= start4_reg ? quo : '0;
        end
    end

    assign out_valid      = v5_reg;
    assign frame_started  = started5_reg;
    assign smoothed_delta = delta5_reg;

    `FPR_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(HIST_D), "history count out of range")
    `FPR_ASSERT_IMPLY(a_empty_sum, count_reg == '0, hist_sum_reg == '0, "sum nonzero with empty history")
    `FPR_ASSERT_NEXT(a_hold_start, fire1 && !start_now, $stable(start_time_reg), "start time moved without a frame start")
    `FPR_ASSERT_IMPLY(a_rem_bound, v4_reg, rem < (SUM_W'(d4) << 1), "reciprocal estimate off by more than one")
    `FPR_ASSERT_IMPLY(a_idle_delta, out_valid && !frame_started, smoothed_delta == '0, "nonzero delta without frame start")

endmodule

`default_nettype wire
